// File: src/gct_pkg.sv
// ============================================================================
// gct_pkg: shared types and constants of the gravity tilt filter
// Register indexes, fixed-point constants, controller states and the
// command/status words between controller and datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package gct_pkg;

    localparam int FRAC_BITS_DEF = 14;

    // raw count * us to rad is RATE_SCALE / 2^48, applied as two 2^24 steps
    localparam int RATE_SCALE = 37501;
    localparam int RATE_SHIFT = 24;

    // normalizer brings the largest magnitude into [2^(NORM_TOP-1), 2^NORM_TOP)
    localparam int NORM_TOP   = 30;
    localparam int SQRT_STEPS = NORM_TOP + 1;

    localparam int LAST_AXIS  = 2;
    localparam int TILT_LIM   = 16384;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_BIAS_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SECOND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAU        = 3'd5;

    localparam logic [47:0] ROW_FIRST_RST  = 48'h0000_0000_4000;
    localparam logic [47:0] ROW_SECOND_RST = 48'h0000_4000_0000;
    localparam logic [23:0] TAU_RST        = 24'd100000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NSHIFT,
        S_NSQ,
        S_NSQRT,
        S_NDINIT,
        S_NDIV,
        S_NDONE,
        S_MUL_W,
        S_SUB_C,
        S_MUL_RATE,
        S_RND_T,
        S_MUL_DT,
        S_PRED,
        S_MUL_TAU,
        S_BLEND,
        S_NLOAD,
        S_TILT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       in_load;
        logic       nload_b;
        logic       nadjust;
        logic       nsq;
        logic       nsq_first;
        logic       nsqrt;
        logic       ndinit;
        logic       ndiv;
        logic       accn_load;
        logic       g_load;
        logic       mul_w;
        logic       sub_c;
        logic       mul_rate;
        logic       rnd_t;
        logic       mul_dt;
        logic       pred;
        logic       mul_tau;
        logic       blend;
        logic       tilt_step;
        logic       tilt_first;
        logic [1:0] tilt_sel;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic nzero;
        logic nin_range;
        logic reseed;
    } t_status;

endpackage

`default_nettype wire

// File: src/gct_ctrl.sv
// ============================================================================
// gct_ctrl: sequencer of the gravity tilt filter
// Walks each word through accel normalize; unless the word seeds, gyro prediction
// and blend and a second normalize follow; then tilt products and the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module gct_ctrl #(
    parameter int FRAC_BITS = gct_pkg::FRAC_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  gct_pkg::t_status     i_status,
    output gct_pkg::t_cmd        o_cmd
);

    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int MAX_CNT   = (gct_pkg::SQRT_STEPS > DIV_STEPS) ?
                               gct_pkg::SQRT_STEPS : DIV_STEPS;
    localparam int CNTW      = $clog2(MAX_CNT);

    gct_pkg::t_state r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_pass, n_pass;       // 0: accel pass, 1: blend pass
    logic            r_needs_seed, n_needs_seed;
    logic            r_out_valid, n_out_valid;

    logic seed;
    logic out_free;

    assign seed     = r_needs_seed | i_status.reseed;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gct_pkg::S_IDLE;
            r_cnt        <= '0;
            r_pass       <= 1'b0;
            r_needs_seed <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pass       <= n_pass;
            r_needs_seed <= n_needs_seed;
            r_out_valid  <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pass       = r_pass;
        n_needs_seed = r_needs_seed;
        n_out_valid  = r_out_valid && i_out_stall;
        case (r_state)
            gct_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = gct_pkg::S_NSHIFT;
                    n_pass  = 1'b0;
                end
            end
            gct_pkg::S_NSHIFT: begin
                if (i_status.nzero) begin
                    n_state = gct_pkg::S_NDONE;
                end else if (i_status.nin_range) begin
                    n_state = gct_pkg::S_NSQ;
                    n_cnt   = '0;
                end
            end
            gct_pkg::S_NSQ: begin
                if (r_cnt == CNTW'(gct_pkg::LAST_AXIS)) begin
                    n_state = gct_pkg::S_NSQRT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            gct_pkg::S_NSQRT: begin
                if (r_cnt == CNTW'(gct_pkg::SQRT_STEPS - 1)) begin
                    n_state = gct_pkg::S_NDINIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            gct_pkg::S_NDINIT: begin
                n_state = gct_pkg::S_NDIV;
                n_cnt   = '0;
            end
            gct_pkg::S_NDIV: begin
                if (r_cnt == CNTW'(DIV_STEPS - 1)) begin
                    n_state = gct_pkg::S_NDONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            gct_pkg::S_NDONE: begin
                n_cnt = '0;
                if (r_pass || seed) begin
                    n_state = gct_pkg::S_TILT;
                    if (!r_pass) begin
                        n_needs_seed = 1'b0;
                    end
                end else begin
                    n_state = gct_pkg::S_MUL_W;
                end
            end
            gct_pkg::S_MUL_W:    n_state = gct_pkg::S_SUB_C;
            gct_pkg::S_SUB_C:    n_state = gct_pkg::S_MUL_RATE;
            gct_pkg::S_MUL_RATE: n_state = gct_pkg::S_RND_T;
            gct_pkg::S_RND_T:    n_state = gct_pkg::S_MUL_DT;
            gct_pkg::S_MUL_DT:   n_state = gct_pkg::S_PRED;
            gct_pkg::S_PRED:     n_state = gct_pkg::S_MUL_TAU;
            gct_pkg::S_MUL_TAU:  n_state = gct_pkg::S_BLEND;
            gct_pkg::S_BLEND: begin
                if (r_cnt == CNTW'(gct_pkg::LAST_AXIS)) begin
                    n_state = gct_pkg::S_NLOAD;
                    n_cnt   = '0;
                end else begin
                    n_state = gct_pkg::S_MUL_W;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            gct_pkg::S_NLOAD: begin
                n_state = gct_pkg::S_NSHIFT;
                n_pass  = 1'b1;
            end
            gct_pkg::S_TILT: begin
                if (r_cnt == CNTW'(gct_pkg::LAST_AXIS)) begin
                    n_state = gct_pkg::S_OUT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            gct_pkg::S_OUT: begin
                if (out_free) begin
                    n_state     = gct_pkg::S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = gct_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            gct_pkg::S_IDLE:     o_cmd.in_load = i_in_valid;
            gct_pkg::S_NSHIFT:   o_cmd.nadjust = !i_status.nzero && !i_status.nin_range;
            gct_pkg::S_NSQ: begin
                o_cmd.nsq       = 1'b1;
                o_cmd.nsq_first = (r_cnt == '0);
            end
            gct_pkg::S_NSQRT:    o_cmd.nsqrt  = 1'b1;
            gct_pkg::S_NDINIT:   o_cmd.ndinit = 1'b1;
            gct_pkg::S_NDIV:     o_cmd.ndiv   = 1'b1;
            gct_pkg::S_NDONE: begin
                o_cmd.g_load    = r_pass || seed;
                o_cmd.accn_load = !r_pass && !seed;
            end
            gct_pkg::S_MUL_W:    o_cmd.mul_w    = 1'b1;
            gct_pkg::S_SUB_C:    o_cmd.sub_c    = 1'b1;
            gct_pkg::S_MUL_RATE: o_cmd.mul_rate = 1'b1;
            gct_pkg::S_RND_T:    o_cmd.rnd_t    = 1'b1;
            gct_pkg::S_MUL_DT:   o_cmd.mul_dt   = 1'b1;
            gct_pkg::S_PRED:     o_cmd.pred     = 1'b1;
            gct_pkg::S_MUL_TAU:  o_cmd.mul_tau  = 1'b1;
            gct_pkg::S_BLEND:    o_cmd.blend    = 1'b1;
            gct_pkg::S_NLOAD:    o_cmd.nload_b  = 1'b1;
            gct_pkg::S_TILT: begin
                o_cmd.tilt_step  = 1'b1;
                o_cmd.tilt_first = (r_cnt == '0);
                o_cmd.tilt_sel   = r_cnt[1:0];
            end
            gct_pkg::S_OUT:      o_cmd.out_load = out_free;
            default:             o_cmd = '0;
        endcase
    end

    assign o_in_stall  = (r_state != gct_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: src/gct_norm.sv
// ============================================================================
// gct_norm: vector normalizer datapath
// Magnitude alignment, sum of squares, bit-serial square root and three
// bit-serial dividers producing a unit vector with FRAC_BITS fraction bits.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module gct_norm #(
    parameter int FRAC_BITS = gct_pkg::FRAC_BITS_DEF,
    parameter int NW        = 51
) (
    input  wire logic                   i_clk,
    input  gct_pkg::t_cmd               i_cmd,
    input  wire logic signed [NW-1:0]   i_vec [3],
    output logic signed [FRAC_BITS+1:0] o_vec [3],
    output logic                        o_zero,
    output logic                        o_in_range
);

    localparam int TOP  = gct_pkg::NORM_TOP;
    localparam int SSW  = 2 * TOP + 2;
    localparam int LW   = TOP + 1;
    localparam int NUMW = TOP + FRAC_BITS + 1;
    localparam int QB   = FRAC_BITS + 1;
    localparam int GW   = FRAC_BITS + 2;

    localparam logic [QB-1:0] Q_ONE = QB'(1) << FRAC_BITS;

    logic          r_neg [3];
    logic [NW-1:0] r_mag [3];
    logic [SSW-1:0] r_v, r_r, r_bit;
    logic [QB-1:0] r_nlo [3];
    logic [LW-1:0] r_rem [3];
    logic [QB-1:0] r_q   [3];

    logic [NW-1:0]    mag_in [3];
    logic [NW-1:0]    mag_max;
    logic [2*TOP-1:0] sq;
    logic [SSW-1:0]   sq_sum;
    logic [SSW:0]     trial;
    logic             sqrt_ge;
    logic [LW-1:0]    len;
    logic [NUMW-1:0]  num   [3];
    logic [LW:0]      rem2  [3];
    logic [LW:0]      rdiff [3];
    logic [QB-1:0]    qc    [3];
    logic signed [GW-1:0] qs [3];
    logic             load;

    assign load = i_cmd.in_load | i_cmd.nload_b;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_in[i] = i_vec[i][NW-1] ? (~i_vec[i] + 1'b1) : i_vec[i];
        end
        mag_max = r_mag[0];
        if (r_mag[1] > mag_max) mag_max = r_mag[1];
        if (r_mag[2] > mag_max) mag_max = r_mag[2];
    end

    assign o_zero     = (mag_max == '0);
    assign o_in_range = (mag_max[NW-1:TOP] == '0) && mag_max[TOP-1];

    assign sq     = r_mag[0][TOP-1:0] * r_mag[0][TOP-1:0];
    assign sq_sum = (i_cmd.nsq_first ? '0 : r_v) + SSW'(sq);
    assign trial  = {1'b0, r_r} + {1'b0, r_bit};
    assign sqrt_ge = ({1'b0, r_v} >= trial);
    assign len    = r_r[LW-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i]   = {r_mag[i][TOP-1:0], FRAC_BITS'(0)} + NUMW'(len >> 1);
            rem2[i]  = {r_rem[i], r_nlo[i][QB-1]};
            rdiff[i] = rem2[i] - {1'b0, len};
            qc[i]    = (r_q[i] > Q_ONE) ? Q_ONE : r_q[i];
            qs[i]    = $signed({1'b0, qc[i]});
            o_vec[i] = r_neg[i] ? -qs[i] : qs[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= i_vec[i][NW-1];
                r_mag[i] <= mag_in[i];
                r_q[i]   <= '0;
            end
            r_r   <= '0;
            r_bit <= SSW'(1) << (SSW - 2);
        end else if (i_cmd.nadjust) begin
            // coarse steps first; truncating shifts compose exactly
            for (int i = 0; i < 3; i++) begin
                if (|mag_max[NW-1:TOP+4]) begin
                    r_mag[i] <= r_mag[i] >> 4;
                end else if (|mag_max[NW-1:TOP]) begin
                    r_mag[i] <= r_mag[i] >> 1;
                end else if (mag_max[TOP-1:TOP-5] == '0) begin
                    r_mag[i] <= r_mag[i] << 4;
                end else begin
                    r_mag[i] <= r_mag[i] << 1;
                end
            end
        end else if (i_cmd.nsq) begin
            r_v      <= sq_sum;
            r_mag[0] <= r_mag[1];
            r_mag[1] <= r_mag[2];
            r_mag[2] <= r_mag[0];
        end else if (i_cmd.nsqrt) begin
            if (sqrt_ge) begin
                r_v <= r_v - trial[SSW-1:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end else if (i_cmd.ndinit) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= LW'(num[i][NUMW-1:QB]);
                r_nlo[i] <= num[i][QB-1:0];
                r_q[i]   <= '0;
            end
        end else if (i_cmd.ndiv) begin
            for (int i = 0; i < 3; i++) begin
                if (!rdiff[i][LW]) begin
                    r_rem[i] <= rdiff[i][LW-1:0];
                    r_q[i]   <= {r_q[i][QB-2:0], 1'b1};
                end else begin
                    r_rem[i] <= rem2[i][LW-1:0];
                    r_q[i]   <= {r_q[i][QB-2:0], 1'b0};
                end
                r_nlo[i] <= r_nlo[i] << 1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/gct_dp.sv
// ============================================================================
// gct_dp: datapath of the gravity tilt filter
// Config registers, gravity state, per-axis gyro prediction and blend,
// normalizer, tilt products and the output word register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module gct_dp #(
    parameter int FRAC_BITS = gct_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [gct_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gct_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic signed [15:0]               i_accel_x,
    input  wire logic signed [15:0]               i_accel_y,
    input  wire logic signed [15:0]               i_accel_z,
    input  wire logic signed [15:0]               i_gyro_x,
    input  wire logic signed [15:0]               i_gyro_y,
    input  wire logic signed [15:0]               i_gyro_z,
    input  wire logic [19:0]                      i_dt_us,
    input  wire logic                             i_reseed,
    input  gct_pkg::t_cmd                         i_cmd,
    output gct_pkg::t_status                      o_status,
    output logic signed [15:0]                    o_tilt_x,
    output logic signed [15:0]                    o_tilt_y
);

    localparam int GW   = FRAC_BITS + 2;
    localparam int WW   = 17;
    localparam int CW   = WW + GW + 1;
    localparam int TW   = CW + 17;
    localparam int TW1  = TW + 1;
    localparam int T1W  = TW - gct_pkg::RATE_SHIFT;
    localparam int UW   = T1W + 21;
    localparam int UW1  = UW + 1;
    localparam int DW   = UW - gct_pkg::RATE_SHIFT;
    localparam int PW   = DW + 1;
    localparam int PTW  = PW + 25;
    localparam int ADW  = GW + 21;
    localparam int BW   = PTW + 1;
    localparam int PRW  = 16 + GW;
    localparam int TSW  = GW + 18;
    localparam int TSW1 = TSW + 1;

    localparam logic signed [16:0]  RATE_K = 17'(gct_pkg::RATE_SCALE);
    localparam logic signed [TW:0]  T_HALF = TW1'(1) << (gct_pkg::RATE_SHIFT - 1);
    localparam logic signed [UW:0]  U_HALF = UW1'(1) << (gct_pkg::RATE_SHIFT - 1);
    localparam logic signed [TSW:0] S_HALF = TSW1'(1) << (FRAC_BITS - 1);
    localparam logic signed [TSW:0] S_LIM  = TSW1'(gct_pkg::TILT_LIM);

    // config
    logic signed [15:0] r_bias_x, r_bias_y, r_bias_z;
    logic [47:0]        r_row_a, r_row_b;
    logic [23:0]        r_tau;

    // state and working registers
    logic signed [GW-1:0]  r_g    [3];
    logic signed [GW-1:0]  r_accn [3];
    logic signed [WW-1:0]  r_w    [3];
    logic signed [BW-1:0]  r_b    [3];
    logic [19:0]           r_dt;
    logic                  r_reseed;
    logic signed [WW+GW-1:0] r_m1, r_m2;
    logic signed [CW-1:0]  r_c;
    logic signed [TW-1:0]  r_t;
    logic signed [T1W-1:0] r_t1;
    logic signed [UW-1:0]  r_u;
    logic signed [PW-1:0]  r_p;
    logic signed [PTW-1:0] r_pt;
    logic signed [ADW-1:0] r_ad;
    logic signed [TSW-1:0] r_acc_x, r_acc_y;
    logic signed [15:0]    r_tilt_x, r_tilt_y;

    logic signed [20:0]    dt_s;
    logic signed [24:0]    tau_s;
    logic signed [TW:0]    t_rnd, t_sh;
    logic signed [UW:0]    u_rnd, u_sh;
    logic signed [DW-1:0]  d_s;
    logic signed [BW-1:0]  b_new;
    logic                  tau_dt_zero;
    logic signed [15:0]    coef_a, coef_b;
    logic signed [PRW-1:0] prod_a, prod_b;
    logic signed [TSW:0]   sx_rnd, sx_sh, sy_rnd, sy_sh;
    logic signed [15:0]    tilt_x_n, tilt_y_n;
    logic signed [BW-1:0]  nvec_in [3];
    logic signed [GW-1:0]  nvec_out [3];
    logic                  n_zero, n_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_x <= '0;
            r_bias_y <= '0;
            r_bias_z <= '0;
            r_row_a  <= gct_pkg::ROW_FIRST_RST;
            r_row_b  <= gct_pkg::ROW_SECOND_RST;
            r_tau    <= gct_pkg::TAU_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gct_pkg::REG_BIAS_X:     r_bias_x <= i_cfg_data[15:0];
                gct_pkg::REG_BIAS_Y:     r_bias_y <= i_cfg_data[15:0];
                gct_pkg::REG_BIAS_Z:     r_bias_z <= i_cfg_data[15:0];
                gct_pkg::REG_ROW_FIRST:  r_row_a  <= i_cfg_data;
                gct_pkg::REG_ROW_SECOND: r_row_b  <= i_cfg_data;
                gct_pkg::REG_TAU:        r_tau    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign dt_s        = {1'b0, r_dt};
    assign tau_s       = {1'b0, r_tau};
    assign tau_dt_zero = (r_tau == '0) && (r_dt == '0);

    assign t_rnd = TW1'(r_t) + T_HALF;
    assign t_sh  = t_rnd >>> gct_pkg::RATE_SHIFT;
    assign u_rnd = UW1'(r_u) + U_HALF;
    assign u_sh  = u_rnd >>> gct_pkg::RATE_SHIFT;
    assign d_s   = u_sh[DW-1:0];
    assign b_new = tau_dt_zero ? BW'(r_p) : (BW'(r_pt) + BW'(r_ad));

    always_comb begin
        case (i_cmd.tilt_sel)
            2'd0: begin
                coef_a = r_row_a[15:0];
                coef_b = r_row_b[15:0];
            end
            2'd1: begin
                coef_a = r_row_a[31:16];
                coef_b = r_row_b[31:16];
            end
            default: begin
                coef_a = r_row_a[47:32];
                coef_b = r_row_b[47:32];
            end
        endcase
    end

    assign prod_a = coef_a * r_g[i_cmd.tilt_sel];
    assign prod_b = coef_b * r_g[i_cmd.tilt_sel];

    assign sx_rnd = TSW1'(r_acc_x) + S_HALF;
    assign sx_sh  = sx_rnd >>> FRAC_BITS;
    assign sy_rnd = TSW1'(r_acc_y) + S_HALF;
    assign sy_sh  = sy_rnd >>> FRAC_BITS;

    always_comb begin
        if (sx_sh > S_LIM)       tilt_x_n = 16'(gct_pkg::TILT_LIM);
        else if (sx_sh < -S_LIM) tilt_x_n = -16'(gct_pkg::TILT_LIM);
        else                     tilt_x_n = sx_sh[15:0];
        if (sy_sh > S_LIM)       tilt_y_n = 16'(gct_pkg::TILT_LIM);
        else if (sy_sh < -S_LIM) tilt_y_n = -16'(gct_pkg::TILT_LIM);
        else                     tilt_y_n = sy_sh[15:0];
    end

    always_comb begin
        if (i_cmd.nload_b) begin
            for (int i = 0; i < 3; i++) nvec_in[i] = r_b[i];
        end else begin
            nvec_in[0] = BW'(i_accel_x);
            nvec_in[1] = BW'(i_accel_y);
            nvec_in[2] = BW'(i_accel_z);
        end
    end

    gct_norm #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (BW)
    ) u_norm (
        .i_clk      (i_clk),
        .i_cmd      (i_cmd),
        .i_vec      (nvec_in),
        .o_vec      (nvec_out),
        .o_zero     (n_zero),
        .o_in_range (n_in_range)
    );

    // gravity estimate; rotated with w and accn while the axes are walked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g[0] <= '0;
            r_g[1] <= '0;
            r_g[2] <= GW'(1) << FRAC_BITS;
        end else if (i_cmd.g_load) begin
            for (int i = 0; i < 3; i++) r_g[i] <= nvec_out[i];
        end else if (i_cmd.blend) begin
            r_g[0] <= r_g[1];
            r_g[1] <= r_g[2];
            r_g[2] <= r_g[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_w[0]   <= WW'(i_gyro_x) - WW'(r_bias_x);
            r_w[1]   <= WW'(i_gyro_y) - WW'(r_bias_y);
            r_w[2]   <= WW'(i_gyro_z) - WW'(r_bias_z);
            r_dt     <= i_dt_us;
            r_reseed <= i_reseed;
        end
        if (i_cmd.accn_load) begin
            for (int i = 0; i < 3; i++) r_accn[i] <= nvec_out[i];
        end
        if (i_cmd.mul_w) begin
            // axis in slot 0: c = w1*g2 - w2*g1
            r_m1 <= r_w[1] * r_g[2];
            r_m2 <= r_w[2] * r_g[1];
        end
        if (i_cmd.sub_c)    r_c  <= CW'(r_m1) - CW'(r_m2);
        if (i_cmd.mul_rate) r_t  <= r_c * RATE_K;
        if (i_cmd.rnd_t)    r_t1 <= t_sh[T1W-1:0];
        if (i_cmd.mul_dt)   r_u  <= r_t1 * dt_s;
        if (i_cmd.pred)     r_p  <= PW'(r_g[0]) - PW'(d_s);
        if (i_cmd.mul_tau) begin
            r_pt <= r_p * tau_s;
            r_ad <= r_accn[0] * dt_s;
        end
        if (i_cmd.blend) begin
            r_b[0]    <= r_b[1];
            r_b[1]    <= r_b[2];
            r_b[2]    <= b_new;
            r_w[0]    <= r_w[1];
            r_w[1]    <= r_w[2];
            r_w[2]    <= r_w[0];
            r_accn[0] <= r_accn[1];
            r_accn[1] <= r_accn[2];
            r_accn[2] <= r_accn[0];
        end
        if (i_cmd.tilt_step) begin
            r_acc_x <= (i_cmd.tilt_first ? '0 : r_acc_x) + TSW'(prod_a);
            r_acc_y <= (i_cmd.tilt_first ? '0 : r_acc_y) + TSW'(prod_b);
        end
        if (i_cmd.out_load) begin
            r_tilt_x <= tilt_x_n;
            r_tilt_y <= tilt_y_n;
        end
    end

    assign o_status.nzero     = n_zero;
    assign o_status.nin_range = n_in_range;
    assign o_status.reseed    = r_reseed;
    assign o_tilt_x           = r_tilt_x;
    assign o_tilt_y           = r_tilt_y;

endmodule

`default_nettype wire

// File: src/gravity_complementary_tilt_top.sv
// ============================================================================
// gravity_complementary_tilt_top: gravity-vector complementary tilt filter
// One accel/gyro sample in, two saturated Q1.14 tilts out.
// ============================================================================
//  channel | valid      | stall       | words
//  --------+------------+-------------+-----------------------------------------
//  in      | i_in_valid | o_in_stall  | accel xyz, gyro xyz, dt_us, reseed
//  out     | o_out_valid| i_out_stall | tilt_x, tilt_y
//  cfg     | i_cfg_we   | (none)      | index 0..5, data 48 bit
//
//  One word at a time. The seed path runs the normalizer once, on the accel
//  vector; the filter path runs it twice, on the accel vector and then on the
//  blend vector. The normalizer aligns the magnitudes, sums the squares, then
//  runs a bit-serial square root and a bit-serial division that gives
//  FRAC_BITS+1 quotient bits; the filter path adds an 8-step multiply chain
//  per axis for the gyro prediction and blend.
//  An output stall holds the sequencer in its output state while the previous result still waits.
//  Reset: synchronous active low; gravity (0,0,1) and seeds on the next word.
//  The next input word is taken while a finished result waits in the out reg.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module gravity_complementary_tilt_top #(
    parameter int FRAC_BITS = gct_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [15:0]             i_accel_x,
    input  wire logic signed [15:0]             i_accel_y,
    input  wire logic signed [15:0]             i_accel_z,
    input  wire logic signed [15:0]             i_gyro_x,
    input  wire logic signed [15:0]             i_gyro_y,
    input  wire logic signed [15:0]             i_gyro_z,
    input  wire logic [19:0]                    i_dt_us,
    input  wire logic                           i_reseed,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [15:0]                  o_tilt_x,
    output logic signed [15:0]                  o_tilt_y
);

    gct_pkg::t_cmd    cmd;
    gct_pkg::t_status status;

    gct_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gct_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_gyro_x    (i_gyro_x),
        .i_gyro_y    (i_gyro_y),
        .i_gyro_z    (i_gyro_z),
        .i_dt_us     (i_dt_us),
        .i_reseed    (i_reseed),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_tilt_x    (o_tilt_x),
        .o_tilt_y    (o_tilt_y)
    );

endmodule

`default_nettype wire

// File: tb/tilt_checker.sv
// ============================================================================
// tilt_checker: predicts and checks the tilt words of the gravity filter
// Watches the config port and both channels. It keeps its own gravity estimate
// and register copies, works out the expected tilts for each accepted input
// word and compares them with the output words in order.
// ============================================================================
`timescale 1ns / 1ps

module tilt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic [19:0]        i_dt_us,
    input  logic               i_reseed,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_tilt_x,
    input  logic signed [15:0] i_tilt_y,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int F = gct_pkg::FRAC_BITS_DEF;

    typedef longint t_vec [3];
    typedef struct packed {
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
    } t_tilt_word;

    longint     gyro_bias [3];
    logic [47:0] row_first;
    logic [47:0] row_second;
    longint     tau_us;
    t_vec       gravity;
    bit         seed_pending;
    t_tilt_word tilt_queue [$];

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void unit_vec(input t_vec v, output t_vec o);
        longint unsigned mag [3];
        longint unsigned m;
        longint unsigned ss;
        longint unsigned len;
        longint unsigned q;
        m = 0;
        ss = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            o = v;
            return;
        end
        while (m >= (64'd1 << gct_pkg::NORM_TOP)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << (gct_pkg::NORM_TOP - 1))) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++) ss += mag[i] * mag[i];
        len = isqrt(ss);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << F) + (len >> 1)) / len;
            if (q > (64'd1 << F)) q = 64'd1 << F;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic logic signed [15:0] row_dot(input logic [47:0] row);
        longint s;
        longint t;
        s = 0;
        for (int i = 0; i < 3; i++) s += longint'($signed(row[16*i +: 16])) * gravity[i];
        t = (s + (64'sd1 <<< (F - 1))) >>> F;
        if (t > gct_pkg::TILT_LIM) t = gct_pkg::TILT_LIM;
        if (t < -gct_pkg::TILT_LIM) t = -gct_pkg::TILT_LIM;
        return t[15:0];
    endfunction

    function automatic t_tilt_word filter_step(input t_vec raw, input t_vec gyro,
                                               input longint dt, input bit reseed);
        t_vec       accn;
        t_vec       w;
        t_vec       c;
        t_vec       blend;
        longint     half;
        longint     t1;
        longint     d;
        longint     p;
        t_tilt_word r;
        half = 64'sd1 <<< (gct_pkg::RATE_SHIFT - 1);
        unit_vec(raw, accn);
        if (seed_pending || reseed) begin
            gravity = accn;
            seed_pending = 1'b0;
        end else begin
            for (int i = 0; i < 3; i++) w[i] = gyro[i] - gyro_bias[i];
            c[0] = w[1] * gravity[2] - w[2] * gravity[1];
            c[1] = w[2] * gravity[0] - w[0] * gravity[2];
            c[2] = w[0] * gravity[1] - w[1] * gravity[0];
            for (int i = 0; i < 3; i++) begin
                t1 = (c[i] * gct_pkg::RATE_SCALE + half) >>> gct_pkg::RATE_SHIFT;
                d = (t1 * dt + half) >>> gct_pkg::RATE_SHIFT;
                p = gravity[i] - d;
                blend[i] = (tau_us + dt == 0) ? p : p * tau_us + accn[i] * dt;
            end
            unit_vec(blend, gravity);
        end
        r.tilt_x = row_dot(row_first);
        r.tilt_y = row_dot(row_second);
        return r;
    endfunction

    assign o_pending = tilt_queue.size();

    always @(posedge i_clk) begin
        t_vec       raw;
        t_vec       gyro;
        t_tilt_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) gyro_bias[i] = 0;
            row_first = gct_pkg::ROW_FIRST_RST;
            row_second = gct_pkg::ROW_SECOND_RST;
            tau_us = longint'(gct_pkg::TAU_RST);
            gravity[0] = 0;
            gravity[1] = 0;
            gravity[2] = 64'sd1 <<< F;
            seed_pending = 1'b1;
            tilt_queue.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gct_pkg::REG_BIAS_X:
                        gyro_bias[0] = longint'($signed(i_cfg_data[15:0]));
                    gct_pkg::REG_BIAS_Y:
                        gyro_bias[1] = longint'($signed(i_cfg_data[15:0]));
                    gct_pkg::REG_BIAS_Z:
                        gyro_bias[2] = longint'($signed(i_cfg_data[15:0]));
                    gct_pkg::REG_ROW_FIRST:  row_first = i_cfg_data;
                    gct_pkg::REG_ROW_SECOND: row_second = i_cfg_data;
                    gct_pkg::REG_TAU:        tau_us = longint'(i_cfg_data[23:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (tilt_queue.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected tilt word x=%0d y=%0d", i_tilt_x, i_tilt_y);
                end else begin
                    want = tilt_queue.pop_front();
                    if (want.tilt_x !== i_tilt_x || want.tilt_y !== i_tilt_y) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("tilt mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                     want.tilt_x, want.tilt_y, i_tilt_x, i_tilt_y);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                raw[0] = longint'(i_accel_x);
                raw[1] = longint'(i_accel_y);
                raw[2] = longint'(i_accel_z);
                gyro[0] = longint'(i_gyro_x);
                gyro[1] = longint'(i_gyro_y);
                gyro[2] = longint'(i_gyro_z);
                tilt_queue.push_back(filter_step(raw, gyro, longint'(i_dt_us), i_reseed));
            end
        end
    end

endmodule

// File: tb/tb_top.sv
// ============================================================================
// tb_top: stimulus and verdict for the gravity complementary tilt filter
// Runs directed corner words and then mostly plausible IMU streams with random
// noise words, over several register settings, with random gaps and output
// stalls including one long hold-off. Checking lives in tilt_checker.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic [2:0] REG_SPARE  = 3'd7;
    localparam int SETTLE_CYCLES = 200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [47:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
    logic [19:0]        dt_us = '0;
    logic               reseed = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] tilt_x, tilt_y;
    int                 errors;
    int                 pending;
    bit                 calm = 1'b0;
    bit                 hold_off = 1'b0;

    always #5 clk = ~clk;

    gravity_complementary_tilt_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_accel_x(accel_x), .i_accel_y(accel_y), .i_accel_z(accel_z),
        .i_gyro_x(gyro_x), .i_gyro_y(gyro_y), .i_gyro_z(gyro_z),
        .i_dt_us(dt_us), .i_reseed(reseed),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_tilt_x(tilt_x), .o_tilt_y(tilt_y)
    );

    tilt_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_accel_x(accel_x), .i_accel_y(accel_y), .i_accel_z(accel_z),
        .i_gyro_x(gyro_x), .i_gyro_y(gyro_y), .i_gyro_z(gyro_z),
        .i_dt_us(dt_us), .i_reseed(reseed),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_tilt_x(tilt_x), .i_tilt_y(tilt_y),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        if (calm) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    // receiver side: random stalls, or a long hold-off when asked
    always @(negedge clk) begin
        int n;
        if (hold_off) begin
            out_stall = 1'b1;
        end else begin
            n = gap_len();
            out_stall = (n > 0);
            repeat (n) @(negedge clk);
            out_stall = 1'b0;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_word(input logic [15:0] ax, ay, az, gx, gy, gz,
                             input logic [19:0] dt, input logic rs);
        int n;
        n = gap_len();
        repeat (n) @(negedge clk);
        accel_x = ax; accel_y = ay; accel_z = az;
        gyro_x = gx; gyro_y = gy; gyro_z = gz;
        dt_us = dt;
        reseed = rs;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [15:0] near(input int centre, input int spread);
        return 16'(centre + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic random_words(input int count);
        logic [15:0] a [3];
        int          up;
        int          sgn;
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                send_word(16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom),
                          20'($urandom_range(0, 1048575)), 1'($urandom_range(0, 1)));
            end else begin
                up = $urandom_range(0, 2);
                sgn = ($urandom_range(0, 1) == 0) ? 1 : -1;
                for (int i = 0; i < 3; i++)
                    a[i] = (i == up) ? near(sgn * 16384, 2000) : near(0, 3000);
                send_word(a[0], a[1], a[2], near(0, 600), near(0, 600), near(0, 600),
                          20'($urandom_range(500, 5000)), $urandom_range(0, 49) == 0);
            end
        end
    endtask

    function automatic logic [47:0] rand_row();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    initial begin
        #50_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first word seeds; then corners of accel, gyro and dt
        send_word(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 20'd1000, 1'b0);
        send_word(16'sd0, 16'sd0, 16'sd16000, 16'sd100, -16'sd50, 16'sd20, 20'd1000, 1'b0);
        send_word(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 20'hfffff,
                  1'b0);
        send_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 20'hfffff,
                  1'b0);
        send_word(16'h7fff, 16'h8000, 16'sd1, 16'h8000, 16'h7fff, 16'sd0, 20'd0, 1'b0);
        // zero accel, seeded and filtered
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd300, 16'sd300, 16'sd300, 20'd1000, 1'b0);
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1000, 1'b1);
        // estimate zero, accel zero: blend vector zero
        send_word(16'sd0, 16'sd0, 16'sd0, 16'sd500, 16'sd0, 16'sd0, 20'd2000, 1'b0);
        // estimate zero, accel present, dt zero: still zero
        send_word(16'sd0, 16'sd9000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd0, 1'b0);
        send_word(16'sd0, 16'sd9000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1000, 1'b0);
        send_word(16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd0, 1'b1);
        send_word(-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1, 1'b0);
        send_word(16'sd0, 16'sd0, -16'sd16384, 16'h7fff, 16'sd0, 16'sd0, 20'hfffff, 1'b0);
        drain();

        // tau zero with dt zero: blend is the prediction
        write_reg(gct_pkg::REG_TAU, 48'd0);
        write_reg(gct_pkg::REG_BIAS_X, 48'h7fff);
        write_reg(gct_pkg::REG_BIAS_Y, 48'h8000);
        write_reg(gct_pkg::REG_BIAS_Z, 48'hffff);
        write_reg(gct_pkg::REG_ROW_FIRST, 48'h8000_8000_8000);
        write_reg(gct_pkg::REG_ROW_SECOND, 48'h7fff_7fff_7fff);
        write_reg(REG_UNUSED, 48'hffff_ffff_ffff);
        write_reg(REG_SPARE, 48'h1234);
        send_word(16'sd100, 16'sd200, 16'sd16000, 16'sd0, 16'sd0, 16'sd0, 20'd0, 1'b1);
        send_word(16'sd100, 16'sd200, 16'sd16000, 16'sd50, 16'sd0, 16'sd0, 20'd0, 1'b0);
        send_word(16'sd100, 16'sd200, 16'sd16000, 16'sd50, 16'sd0, 16'sd0, 20'd7, 1'b0);
        send_word(16'h8000, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, 16'sd1, 20'hfffff, 1'b0);
        random_words(200);
        drain();

        write_reg(gct_pkg::REG_TAU, 48'd1);
        write_reg(gct_pkg::REG_BIAS_X, 48'd0);
        write_reg(gct_pkg::REG_BIAS_Y, 48'd0);
        write_reg(gct_pkg::REG_BIAS_Z, 48'd0);
        write_reg(gct_pkg::REG_ROW_FIRST, gct_pkg::ROW_FIRST_RST);
        write_reg(gct_pkg::REG_ROW_SECOND, gct_pkg::ROW_SECOND_RST);
        calm = 1'b1;
        random_words(200);
        calm = 1'b0;
        // long hold-off on the output while words keep coming
        hold_off = 1'b1;
        fork
            random_words(60);
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        drain();

        write_reg(gct_pkg::REG_TAU, 48'hff_ffff);
        write_reg(gct_pkg::REG_BIAS_X, 48'($urandom_range(0, 400)));
        write_reg(gct_pkg::REG_BIAS_Y, 48'($urandom_range(0, 400)));
        write_reg(gct_pkg::REG_ROW_FIRST, 48'h0000_2d41_2d41);
        write_reg(gct_pkg::REG_ROW_SECOND, 48'h2d41_d2bf_0000);
        random_words(400);
        drain();

        write_reg(gct_pkg::REG_TAU, 48'($urandom_range(20000, 300000)));
        write_reg(gct_pkg::REG_BIAS_Z, 48'($urandom));
        write_reg(gct_pkg::REG_ROW_FIRST, rand_row());
        write_reg(gct_pkg::REG_ROW_SECOND, rand_row());
        random_words(450);
        drain();

        write_reg(gct_pkg::REG_TAU, 48'(gct_pkg::TAU_RST));
        write_reg(gct_pkg::REG_ROW_FIRST, rand_row());
        write_reg(gct_pkg::REG_ROW_SECOND, rand_row());
        random_words(450);
        drain();

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: filelist.f
src/gct_pkg.sv
src/gct_ctrl.sv
src/gct_norm.sv
src/gct_dp.sv
src/gravity_complementary_tilt_top.sv
tb/tilt_checker.sv
tb/tb_top.sv
